// ----- sv/sawbc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawbc_pkg
// shared types and codes of the set-associative write-back cache
// ----------------------------------------------------------------------------
package sawbc_pkg;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_FILL  = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  localparam logic [1:0] KIND_READ = 2'd0;
  localparam logic [1:0] KIND_WDONE = 2'd1;
  localparam logic [1:0] KIND_WBACK = 2'd2;
  localparam logic [1:0] KIND_FILLREQ = 2'd3;

  localparam logic REG_SIZE = 1'b0;
  localparam logic REG_WAYS = 1'b1;

  localparam int OFFSET_BITS = 6;
  localparam logic [15:0] LFSR_SEED = 16'hACE1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] word;
    logic [25:0] mem_block;
    logic [3:0]  word_index;
    logic        last;
  } result_t;

  // one entry of the tag store
  typedef struct packed {
    logic        valid;
    logic        dirty;
    logic [25:0] tag;
  } tag_entry_t;

endpackage

// ----- sv/set_assoc_write_back_cache_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_write_back_cache_top
// write-back, write-allocate cache with random replacement
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries accesses (read, masked write) and refill words; m_axis
//   carries read data, write acknowledges, writeback words and refill
//   requests. a transaction of cmd 2 delivers one refill word.
//   an access probes the tags of the set one way at a time, in a probe and
//   a check state each, until a hit; a hit goes on through the data read
//   and done states to its result. a miss gives the refill request after
//   all ways are probed; a dirty eviction first reads the victim tag and
//   sends each writeback word through a read, a load and an output state
//   before the request. refill words are taken one per cycle; the last one
//   leads through the data read and done states to the read or write result.
//   the result is held in an output register and s_axis_tready stays low
//   until it leaves, so a stalled receiver stalls the input.
//   reset and every configuration write start a clearing pass over all
//   2**LINES_LOG2 entries (1024 by default) that zeroes the valid and dirty
//   bits, with s_axis_tready low; the lfsr returns to its seed at reset.
// ----------------------------------------------------------------------------
module set_assoc_write_back_cache_top #(
  parameter int LINES_LOG2 = 10
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // addr, data, write_mask
  input  logic [1:0]   s_axis_tuser,   // cmd
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,   // word, mem_block, word_index, zero fill
  output logic [1:0]   m_axis_tuser,   // kind
  output logic         m_axis_tlast,   // last
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [4:0]   cfg_data
);
  localparam int LA = LINES_LOG2 + 4;

  typedef enum logic [10:0] {
    S_CLEAR  = 11'b00000000001,
    S_IDLE   = 11'b00000000010,
    S_PROBE  = 11'b00000000100,
    S_CHECK  = 11'b00000001000,
    S_VICTIM = 11'b00000010000,
    S_EVICT  = 11'b00000100000,
    S_WBRD   = 11'b00001000000,
    S_WBOUT  = 11'b00010000000,
    S_DREAD  = 11'b00100000000,
    S_DONE   = 11'b01000000000,
    S_OUT    = 11'b10000000000
  } state_t;

  state_t state;
  logic [4:0] size_reg;
  logic [2:0] ways_reg;
  logic [15:0] lfsr;
  logic waiting;
  logic [4:0] fill_count;
  logic [LINES_LOG2-1:0] fill_line;
  logic [LINES_LOG2-1:0] clr_idx;
  logic [31:0] p_addr, p_data, p_mask;
  logic p_write;
  logic [7:0] way;
  logic [LINES_LOG2-1:0] line;
  logic [3:0] widx;
  logic [25:0] wb_block;
  logic have_free;
  logic [LINES_LOG2-1:0] free_line;
  sawbc_pkg::result_t res;

  logic [4:0] lu, wl, sb;
  logic [LINES_LOG2-1:0] set_idx, base, probe_line, vic_line;
  logic [25:0] tag_a;
  logic [15:0] lfsr_next;
  logic last_way;

  // memory ports
  logic lr_we, tr_we;
  logic [LA-1:0] lr_addr;
  logic [31:0] lr_wdata, lr_rdata;
  logic [LINES_LOG2-1:0] tr_addr;
  sawbc_pkg::tag_entry_t tr_wdata, tr_rdata;

  logic acc_in;
  logic fill_in;
  logic fill_done;
  logic fill_tag_we;
  logic hit;
  logic [31:0] merged;

  always_comb begin
    if (size_reg < 5'd6) lu = 5'd0;
    else if (size_reg > 5'(6 + LINES_LOG2)) lu = 5'(LINES_LOG2);
    else lu = size_reg - 5'd6;
    wl = ({2'b0, ways_reg} > lu) ? lu : {2'b0, ways_reg};
    sb = lu - wl;
    set_idx = LINES_LOG2'((p_addr >> sawbc_pkg::OFFSET_BITS)
              & ((32'd1 << sb) - 32'd1));
    tag_a = 26'(p_addr >> (sawbc_pkg::OFFSET_BITS + 32'(sb)));
    base = LINES_LOG2'({ {(32-LINES_LOG2){1'b0}}, set_idx} << wl);
    probe_line = base + LINES_LOG2'(way);
    last_way = (way == (8'd1 << wl) - 8'd1);
    lfsr_next = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[15:1]};
    vic_line = base + LINES_LOG2'(lfsr_next & ((16'd1 << wl) - 16'd1));
  end

  sawbc_line_ram #(.AW(LA)) u_lines (
    .clk(clk), .we(lr_we), .addr(lr_addr), .wdata(lr_wdata), .rdata(lr_rdata));
  sawbc_tag_ram #(.AW(LINES_LOG2)) u_tags (
    .clk(clk), .we(tr_we), .addr(tr_addr), .wdata(tr_wdata), .rdata(tr_rdata));

  assign s_axis_tready = (state == S_IDLE);
  assign acc_in = s_axis_tvalid && s_axis_tready;
  assign fill_in = acc_in && s_axis_tuser == sawbc_pkg::CMD_FILL && waiting;
  assign fill_done = fill_in && fill_count == 5'd15;
  assign hit = tr_rdata.valid && tr_rdata.tag == tag_a;
  assign merged = (lr_rdata & ~p_mask) | (p_data & p_mask);

  // tag written when the refill request leaves
  assign fill_tag_we = state == S_OUT && m_axis_tready
                       && res.kind == sawbc_pkg::KIND_FILLREQ;

  always_comb begin
    lr_we = 1'b0;
    lr_addr = {line, p_addr[5:2]};
    lr_wdata = merged;
    tr_we = 1'b0;
    tr_addr = probe_line;
    tr_wdata = '{1'b0, 1'b0, tag_a};
    unique case (state)
      S_CLEAR: begin
        tr_we = 1'b1;
        tr_addr = clr_idx;
        tr_wdata = '0;
      end
      S_IDLE: begin
        lr_addr = {fill_line, fill_count[3:0]};
        lr_wdata = s_axis_tdata[63:32];
        lr_we = fill_in;
        tr_addr = fill_line;
        tr_we = fill_done;
        tr_wdata = '{1'b1, 1'b0, tag_a};
      end
      S_PROBE, S_CHECK: ;
      S_VICTIM, S_EVICT: tr_addr = line;
      S_WBRD, S_WBOUT: lr_addr = {line, widx};
      S_DREAD: ;
      S_DONE: begin
        lr_we = p_write;
        tr_addr = line;
        tr_we = p_write;
        tr_wdata = '{1'b1, 1'b1, tag_a};
      end
      S_OUT: begin
        tr_addr = line;
        tr_we = fill_tag_we;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      if (rst) begin
        size_reg <= 5'd16;
        ways_reg <= 3'd2;
        lfsr <= sawbc_pkg::LFSR_SEED;
        fill_line <= '0;
      end else if (cfg_index == sawbc_pkg::REG_SIZE) begin
        size_reg <= cfg_data;
      end else begin
        ways_reg <= cfg_data[2:0];
      end
      waiting <= 1'b0;
      fill_count <= '0;
      clr_idx <= '0;
      state <= S_CLEAR;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (&clr_idx) state <= S_IDLE;
          clr_idx <= clr_idx + LINES_LOG2'(1);
        end
        S_IDLE: if (acc_in) begin
          if (s_axis_tuser == sawbc_pkg::CMD_FILL) begin
            if (waiting) begin
              if (fill_count == 5'd15) begin
                waiting <= 1'b0;
                fill_count <= '0;
                line <= fill_line;
                state <= S_DREAD;
              end else begin
                fill_count <= fill_count + 5'd1;
              end
            end
          end else if ((s_axis_tuser == sawbc_pkg::CMD_READ ||
                        s_axis_tuser == sawbc_pkg::CMD_WRITE) && !waiting) begin
            p_addr <= s_axis_tdata[31:0];
            p_data <= s_axis_tdata[63:32];
            p_mask <= s_axis_tdata[95:64];
            p_write <= (s_axis_tuser == sawbc_pkg::CMD_WRITE);
            way <= '0;
            have_free <= 1'b0;
            state <= S_PROBE;
          end
        end
        S_PROBE: state <= S_CHECK;
        S_CHECK: begin
          if (hit) begin
            line <= probe_line;
            state <= S_DREAD;
          end else begin
            if (!tr_rdata.valid && !have_free) begin
              have_free <= 1'b1;
              free_line <= probe_line;
            end
            if (last_way) begin
              if (have_free || !tr_rdata.valid) begin
                line <= have_free ? free_line : probe_line;
                res <= '{sawbc_pkg::KIND_FILLREQ, 32'd0, p_addr[31:6], 4'd0, 1'b1};
                state <= S_OUT;
              end else begin
                lfsr <= lfsr_next;
                line <= vic_line;
                state <= S_VICTIM;
              end
            end else begin
              way <= way + 8'd1;
              state <= S_PROBE;
            end
          end
        end
        S_VICTIM: state <= S_EVICT;
        S_EVICT: begin
          // victim tag read issued last cycle is valid now
          if (tr_rdata.dirty) begin
            wb_block <= 26'((32'(tr_rdata.tag) << sb) | 32'(set_idx));
            widx <= '0;
            state <= S_WBRD;
          end else begin
            res <= '{sawbc_pkg::KIND_FILLREQ, 32'd0, p_addr[31:6], 4'd0, 1'b1};
            state <= S_OUT;
          end
        end
        S_WBRD: state <= S_WBOUT;
        S_WBOUT: begin
          res <= '{sawbc_pkg::KIND_WBACK, lr_rdata, wb_block, widx, 1'b0};
          state <= S_OUT;
        end
        S_DREAD: state <= S_DONE;
        S_DONE: begin
          if (p_write) begin
            res <= '{sawbc_pkg::KIND_WDONE, 32'd0, 26'd0, 4'd0, 1'b1};
          end else begin
            res <= '{sawbc_pkg::KIND_READ, lr_rdata, 26'd0, 4'd0, 1'b1};
          end
          state <= S_OUT;
        end
        S_OUT: if (m_axis_tready) begin
          if (res.kind == sawbc_pkg::KIND_WBACK) begin
            if (widx == 4'd15) begin
              res <= '{sawbc_pkg::KIND_FILLREQ, 32'd0, p_addr[31:6], 4'd0, 1'b1};
            end else begin
              widx <= widx + 4'd1;
              state <= S_WBRD;
            end
          end else begin
            if (res.kind == sawbc_pkg::KIND_FILLREQ) begin
              fill_line <= line;
              fill_count <= '0;
              waiting <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata = {2'b00, res.word_index, res.mem_block, res.word};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;
endmodule

// ----- sv/sawbc_line_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawbc_line_ram
// word store of all lines, one port, registered read data
// ----------------------------------------------------------------------------
module sawbc_line_ram #(
  parameter int AW = 14
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [31:0]   wdata,
  output logic [31:0]   rdata
);
  logic [31:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ----- sv/sawbc_tag_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawbc_tag_ram
// tag, valid and dirty store, one port, registered read data
// ----------------------------------------------------------------------------
module sawbc_tag_ram #(
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [27:0]   wdata,
  output logic [27:0]   rdata
);
  logic [27:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ----- tb/tb_set_assoc_write_back_cache_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_set_assoc_write_back_cache_top
// self-checking testbench of the set-associative write-back cache
// ----------------------------------------------------------------------------
// reads, masked writes and refill words go in over s_axis while a local
// model of tags, dirty bits, line data and the victim lfsr works out the
// read data, write acknowledges, writebacks and refill requests expected on
// m_axis. the run goes through several cache geometries, random gaps and
// stalls on both sides, and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_set_assoc_write_back_cache_top;

  localparam int NLINES = 1024;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata = '0;   // addr, data, write_mask
  logic [1:0]   s_axis_tuser = '0;   // cmd
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;        // word, mem_block, word_index, zero fill
  logic [1:0]   m_axis_tuser;        // kind
  logic         m_axis_tlast;
  logic         cfg_we = 1'b0;
  logic         cfg_index = 1'b0;
  logic [4:0]   cfg_data = '0;

  set_assoc_write_back_cache_top DUT (.*);

  always #6 clk = ~clk;

  // cache model
  logic [4:0]  size_reg;
  logic [2:0]  ways_reg;
  logic        line_valid [NLINES];
  logic        line_dirty [NLINES];
  logic [25:0] line_tag [NLINES];
  logic [31:0] line_data [NLINES*16];
  logic [15:0] victim_lfsr;
  logic        fill_pending;
  int          fill_pos;
  int          fill_target;
  logic [31:0] miss_addr, miss_data, miss_mask;
  logic        miss_is_write;

  sawbc_pkg::result_t expected_results [$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          wbacks_seen = 0;
  int          items_sent = 0;
  int          hold_cycles = 0;
  bit          no_idle = 0;
  logic [31:0] blocks [8];

  function automatic void clear_lines();
    for (int i = 0; i < NLINES; i++) begin
      line_valid[i] = 0;
      line_dirty[i] = 0;
    end
    fill_pending = 0;
    fill_pos = 0;
  endfunction

  function automatic void expect_result(logic [1:0] kind, logic [31:0] word,
                                        logic [25:0] blk, logic [3:0] idx,
                                        logic lst);
    sawbc_pkg::result_t r;
    r.kind = kind; r.word = word; r.mem_block = blk; r.word_index = idx;
    r.last = lst;
    expected_results.push_back(r);
  endfunction

  function automatic void complete_access(int line);
    int p;
    p = line*16 + miss_addr[5:2];
    if (miss_is_write) begin
      line_data[p] = (line_data[p] & ~miss_mask) | (miss_data & miss_mask);
      line_dirty[line] = 1;
      expect_result(sawbc_pkg::KIND_WDONE, '0, '0, '0, 1'b1);
    end else begin
      expect_result(sawbc_pkg::KIND_READ, line_data[p], '0, '0, 1'b1);
    end
  endfunction

  function automatic void cache_step(logic [1:0] cmd, logic [31:0] addr,
                                     logic [31:0] data, logic [31:0] mask);
    int lines_l2, wl, sb, set_i, base, line;
    logic [31:0] tag, blk;
    bit found;
    if (cmd == sawbc_pkg::CMD_FILL) begin
      if (!fill_pending) return;
      line_data[fill_target*16 + fill_pos] = data;
      fill_pos++;
      if (fill_pos < 16) return;
      line_valid[fill_target] = 1;
      line_dirty[fill_target] = 0;
      fill_pending = 0;
      fill_pos = 0;
      complete_access(fill_target);
      return;
    end
    if (cmd != sawbc_pkg::CMD_READ && cmd != sawbc_pkg::CMD_WRITE) return;
    if (fill_pending) return;
    lines_l2 = size_reg < 6 ? 0 : (size_reg > 16 ? 10 : size_reg - 6);
    wl = ways_reg > lines_l2 ? lines_l2 : ways_reg;
    sb = lines_l2 - wl;
    set_i = (addr >> sawbc_pkg::OFFSET_BITS) & ((1 << sb) - 1);
    tag = addr >> (sawbc_pkg::OFFSET_BITS + sb);
    base = set_i << wl;
    miss_addr = addr; miss_data = data; miss_mask = mask;
    miss_is_write = (cmd == sawbc_pkg::CMD_WRITE);
    found = 0;
    line = 0;
    for (int w = 0; w < (1 << wl) && !found; w++)
      if (line_valid[base+w] && line_tag[base+w] == tag[25:0]) begin
        found = 1; line = base + w;
      end
    if (found) begin
      complete_access(line);
      return;
    end
    for (int w = 0; w < (1 << wl) && !found; w++)
      if (!line_valid[base+w]) begin
        found = 1; line = base + w;
      end
    if (!found) begin
      victim_lfsr = {victim_lfsr[0] ^ victim_lfsr[2] ^ victim_lfsr[3] ^ victim_lfsr[5],
                     victim_lfsr[15:1]};
      line = base + (victim_lfsr & ((1 << wl) - 1));
      if (line_dirty[line]) begin
        blk = ({6'b0, line_tag[line]} << sb) | set_i;
        for (int w = 0; w < 16; w++)
          expect_result(sawbc_pkg::KIND_WBACK, line_data[line*16 + w], blk[25:0],
                        w[3:0], 1'b0);
      end
    end
    line_valid[line] = 0;
    line_dirty[line] = 0;
    line_tag[line] = tag[25:0];
    fill_target = line;
    fill_pos = 0;
    fill_pending = 1;
    expect_result(sawbc_pkg::KIND_FILLREQ, '0, addr[31:6], '0, 1'b1);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_item(logic [1:0] cmd, logic [31:0] addr, logic [31:0] data,
                           logic [31:0] mask);
    int gap;
    s_axis_tuser = cmd;
    s_axis_tdata = {mask, data, addr};
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    cache_step(cmd, addr, data, mask);
    items_sent++;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_fills();
    while (fill_pending) send_item(sawbc_pkg::CMD_FILL, $urandom, $urandom, $urandom);
  endtask

  task automatic access(logic [1:0] cmd, logic [31:0] addr, logic [31:0] data,
                        logic [31:0] mask);
    send_item(cmd, addr, data, mask);
    send_fills();
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [4:0] val);
    drain();
    cfg_we = 1'b1; cfg_index = idx; cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == sawbc_pkg::REG_SIZE) size_reg = val;
    else ways_reg = val[2:0];
    clear_lines();
  endtask

  function automatic logic [31:0] rand_mask();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic new_blocks();
    for (int i = 0; i < 8; i++)
      blocks[i] = (i > 0 && i % 2 == 1) ? (blocks[i-1] ^ ($urandom << 12)) & ~32'h3f
                                         : $urandom & ~32'h3f;
  endtask

  // receiver
  initial begin
    int idle_left;
    idle_left = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        m_axis_tready = 1'b0;
        hold_cycles--;
      end else if (idle_left > 0) begin
        m_axis_tready = 1'b0;
        idle_left--;
      end else begin
        m_axis_tready = 1'b1;
        idle_left = pick_gap();
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    sawbc_pkg::result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.kind = m_axis_tuser;
      got.word = m_axis_tdata[31:0];
      got.mem_block = m_axis_tdata[57:32];
      got.word_index = m_axis_tdata[61:58];
      got.last = m_axis_tlast;
      results_seen++;
      if (got.kind == sawbc_pkg::KIND_WBACK) wbacks_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result kind %0d word %h", got.kind, got.word);
      end else begin
        want = expected_results.pop_front();
        if (got.kind !== want.kind || got.word !== want.word ||
            got.mem_block !== want.mem_block || got.word_index !== want.word_index ||
            got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected kind %0d word %h blk %h idx %0d last %0d,",
                     want.kind, want.word, want.mem_block, want.word_index, want.last);
            $display("          got kind %0d word %h blk %h idx %0d last %0d",
                     got.kind, got.word, got.mem_block, got.word_index, got.last);
          end
        end
      end
    end
  end

  task automatic test_directed();
    // single line, way count clamped to it
    write_reg(sawbc_pkg::REG_SIZE, 5'd6);
    write_reg(sawbc_pkg::REG_WAYS, 5'd4);
    access(sawbc_pkg::CMD_WRITE, 32'h0000_1000, 32'hcafe_f00d, 32'h0ff0_ffff);
    access(sawbc_pkg::CMD_READ, 32'h0000_1003, 32'h0, 32'h0);
    // dirty eviction
    access(sawbc_pkg::CMD_READ, 32'h0000_2008, 32'h0, 32'h0);
    // clean eviction, refill left open
    send_item(sawbc_pkg::CMD_WRITE, 32'h0000_3000, 32'h5, 32'h5);
    send_item(sawbc_pkg::CMD_NOP, 32'h40, 32'h0, 32'h0);
    // access while a refill is outstanding is dropped
    send_item(sawbc_pkg::CMD_READ, 32'h8000_0040, 32'h0, 32'h0);
    send_item(sawbc_pkg::CMD_FILL, 32'h0, 32'h1, 32'h0);
    // a register write abandons the miss after the first word of its refill
    write_reg(sawbc_pkg::REG_SIZE, 5'd0);
    send_item(sawbc_pkg::CMD_FILL, 32'h0, 32'hdead_beef, 32'h0);
    access(sawbc_pkg::CMD_READ, 32'hffff_fffd, 32'h0, 32'h0);
  endtask

  task automatic test_random(int count, logic [4:0] size_v, logic [4:0] ways_v);
    int stop, r;
    logic [31:0] a;
    write_reg(sawbc_pkg::REG_SIZE, size_v);
    write_reg(sawbc_pkg::REG_WAYS, ways_v);
    new_blocks();
    stop = items_sent + count;
    while (items_sent < stop) begin
      no_idle = ((items_sent / 30) % 3 == 2);
      r = $urandom_range(0, 99);
      a = blocks[$urandom_range(0, 7)] | $urandom_range(0, 63);
      if (r < 80) begin
        send_item(2'($urandom_range(0, 1)), a, $urandom, rand_mask());
        while (fill_pending) begin
          if ($urandom_range(0, 19) == 0)
            send_item(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
          else
            send_item(sawbc_pkg::CMD_FILL, $urandom, $urandom, $urandom);
        end
      end else if (r < 90) begin
        send_item(2'($urandom_range(2, 3)), $urandom, $urandom, $urandom);
      end else begin
        access(2'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
      end
    end
    no_idle = 0;
  endtask

  task automatic test_backpressure();
    write_reg(sawbc_pkg::REG_SIZE, 5'd7);
    write_reg(sawbc_pkg::REG_WAYS, 5'd1);
    access(sawbc_pkg::CMD_WRITE, 32'h0000_0100, 32'h1111_2222, 32'hffff_ffff);
    drain();
    hold_cycles = 300;
    for (int i = 0; i < 4; i++)
      access(2'($urandom_range(0, 1)), 32'h0000_0100 | (i * 4), $urandom, $urandom);
  endtask

  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int wait_cycles;
    size_reg = 5'd16;
    ways_reg = 3'd2;
    victim_lfsr = sawbc_pkg::LFSR_SEED;
    clear_lines();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random(6, 5'd7, 5'd1);
    test_random(6, 5'd8, 5'd31);
    test_backpressure();
    test_random(6, 5'd16, 5'd2);
    s_axis_tvalid = 1'b0;
    wait_cycles = 0;
    while (expected_results.size() != 0 && wait_cycles < 100000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (60) @(negedge clk);
    $display("sent %0d transactions over several cache geometries, checked %0d results",
             items_sent, results_seen);
    $display("%0d writeback words seen, long receiver hold-off included", wbacks_seen);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
